// ===== sv/pfd_pkg.sv =====
// Shared types, constants and the control store of the filtered-derivative PID block.
package pfd_pkg;

  // Fixed-point widths
  localparam int unsigned DATA_W  = 32;               // Q16.16 values
  localparam int unsigned GAIN_W  = 24;               // Q8.16 gains
  localparam int unsigned STEP_W  = 16;               // Q0.16 integration step
  localparam int unsigned LIMIT_W = 31;               // integral clamp
  localparam int unsigned OPA_W   = DATA_W + 1;       // multiplier A: exact difference
  localparam int unsigned OPB_W   = GAIN_W + 1;       // multiplier B: gains and Q0.16 consts
  localparam int unsigned PROD_W  = OPA_W + OPB_W;    // 58 bits
  localparam int unsigned ACC_W   = PROD_W + 2;       // room for three products
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned RND_W   = ACC_W - FRAC_W;   // accumulator after the shift
  localparam int unsigned INT_W   = DATA_W + 2;       // integral update width
  localparam int unsigned PC_W    = 4;                // step counter

  // Filter coefficients, Q0.16
  localparam logic [OPB_W-1:0] FILTER_NEW = OPB_W'(25166);
  localparam logic [OPB_W-1:0] FILTER_OLD = OPB_W'(40305);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd4;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = LIMIT_W'(655360);

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [GAIN_W-1:0] gain_i;
    logic [STEP_W-1:0]        int_step;
    logic [LIMIT_W-1:0]       int_limit;
  } cfg_t;

  // Control word fields
  typedef enum logic [2:0] {A_ERR, A_DIFF, A_PREVD, A_INTEG, A_DERIV} asel_t;
  typedef enum logic [2:0] {B_STEP, B_CNEW, B_COLD, B_GP, B_GD, B_GI} bsel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [2:0] {WR_NONE, WR_DIFF, WR_INTEG, WR_DERIV, WR_OUT, WR_CLR} wr_t;

  typedef struct packed {
    asel_t             a_sel;
    bsel_t             b_sel;
    acc_op_t           acc_op;
    wr_t               wr;
    logic              jmp_cmd;   // jump to jmp_to when the item is a clear command
    logic [PC_W-1:0]   jmp_to;
    logic              last;      // hand the result to the output register
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_CLEAR = 4'd8;

  localparam ctrl_t CTRL_NOP = '{a_sel: A_ERR, b_sel: B_STEP, acc_op: ACC_HOLD,
                                 wr: WR_NONE, jmp_cmd: 1'b0, jmp_to: '0, last: 1'b0};

  // Control store. A product is registered in the step after its operands are
  // selected, and the accumulator takes it in the step after that.
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    case (pc)
      4'd0: begin
        // diff and previous error, start err*step
        w.jmp_cmd = 1'b1;
        w.jmp_to  = PC_CLEAR;
        w.wr      = WR_DIFF;
        w.a_sel   = A_ERR;
        w.b_sel   = B_STEP;
      end
      4'd1: begin
        w.acc_op = ACC_LOAD;
        w.a_sel  = A_DIFF;
        w.b_sel  = B_CNEW;
      end
      4'd2: begin
        w.wr     = WR_INTEG;
        w.acc_op = ACC_LOAD;
        w.a_sel  = A_PREVD;
        w.b_sel  = B_COLD;
      end
      4'd3: begin
        w.acc_op = ACC_ADD;
        w.a_sel  = A_ERR;
        w.b_sel  = B_GP;
      end
      4'd4: begin
        w.wr     = WR_DERIV;
        w.acc_op = ACC_LOAD;
        w.a_sel  = A_INTEG;
        w.b_sel  = B_GI;
      end
      4'd5: begin
        w.acc_op = ACC_ADD;
        w.a_sel  = A_DERIV;
        w.b_sel  = B_GD;
      end
      4'd6: begin
        w.acc_op = ACC_ADD;
      end
      4'd7: begin
        w.wr   = WR_OUT;
        w.last = 1'b1;
      end
      4'd8: begin
        w.wr   = WR_CLR;
        w.last = 1'b1;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

  // Saturate the shifted accumulator to 32 bits signed
  function automatic logic [DATA_W-1:0] sat32(logic [RND_W-1:0] v);
    logic ovf;
    ovf = (v[RND_W-1:DATA_W-1] != '0) && (v[RND_W-1:DATA_W-1] != '1);
    if (!ovf) begin
      return v[DATA_W-1:0];
    end else if (v[RND_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== sv/pfd_datapath.sv =====
// Datapath: shared multiplier, rounding accumulator and controller state registers.
module pfd_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [31:0]            setpoint,
  input  logic signed [31:0]            measured,
  input  pfd_pkg::ctrl_t                ctrl,
  input  pfd_pkg::cfg_t                 cfg,
  output logic [pfd_pkg::DATA_W-1:0]    drive
);
  import pfd_pkg::*;

  logic signed [DATA_W-1:0]  err_r;
  logic signed [OPA_W-1:0]   diff_r;
  logic signed [DATA_W-1:0]  prev_err_r, prev_err_nxt;
  logic signed [DATA_W-1:0]  prev_der_r, prev_der_nxt;
  logic signed [DATA_W-1:0]  integ_r, integ_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  logic signed [DATA_W:0]    raw_err;
  logic signed [DATA_W-1:0]  err_sat;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic [RND_W-1:0]          rnd;
  logic [DATA_W-1:0]         rnd_sat;
  logic signed [INT_W-1:0]   int_sum;
  logic signed [INT_W-1:0]   lim_pos;
  logic signed [INT_W-1:0]   lim_neg;
  logic signed [DATA_W-1:0]  int_clamped;

  // Saturated error, taken when the item transfers
  always_comb begin
    raw_err = {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};
    if (raw_err[DATA_W] != raw_err[DATA_W-1]) begin
      err_sat = raw_err[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      err_sat = raw_err[DATA_W-1:0];
    end
  end

  // Operand selection
  always_comb begin
    case (ctrl.a_sel)
      A_ERR:   op_a = {err_r[DATA_W-1], err_r};
      A_DIFF:  op_a = diff_r;
      A_PREVD: op_a = {prev_der_r[DATA_W-1], prev_der_r};
      A_INTEG: op_a = {integ_r[DATA_W-1], integ_r};
      A_DERIV: op_a = {prev_der_r[DATA_W-1], prev_der_r};
      default: op_a = '0;
    endcase
    case (ctrl.b_sel)
      B_STEP:  op_b = {{(OPB_W-STEP_W){1'b0}}, cfg.int_step};
      B_CNEW:  op_b = FILTER_NEW;
      B_COLD:  op_b = FILTER_OLD;
      B_GP:    op_b = {cfg.gain_p[GAIN_W-1], cfg.gain_p};
      B_GD:    op_b = {cfg.gain_d[GAIN_W-1], cfg.gain_d};
      B_GI:    op_b = {cfg.gain_i[GAIN_W-1], cfg.gain_i};
      default: op_b = '0;
    endcase
  end

  // Accumulator; a load starts from one half LSB so the shift rounds half up
  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(prod_r) + ROUND_HALF;
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  assign rnd     = acc_r[ACC_W-1:FRAC_W];
  assign rnd_sat = sat32(rnd);
  assign drive   = rnd_sat;

  // Integral update and clamp
  always_comb begin
    int_sum = INT_W'(integ_r) + rnd[INT_W-1:0];
    lim_pos = INT_W'({1'b0, cfg.int_limit});
    lim_neg = -lim_pos;
    if (int_sum > lim_pos) begin
      int_clamped = lim_pos[DATA_W-1:0];
    end else if (int_sum < lim_neg) begin
      int_clamped = lim_neg[DATA_W-1:0];
    end else begin
      int_clamped = int_sum[DATA_W-1:0];
    end
  end

  // Controller state next values
  always_comb begin
    prev_err_nxt = prev_err_r;
    prev_der_nxt = prev_der_r;
    integ_nxt    = integ_r;
    case (ctrl.wr)
      WR_DIFF:  prev_err_nxt = err_r;
      WR_INTEG: integ_nxt    = int_clamped;
      WR_DERIV: prev_der_nxt = rnd_sat;
      WR_CLR: begin
        prev_err_nxt = '0;
        prev_der_nxt = '0;
        integ_nxt    = '0;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      prev_der_r <= '0;
      integ_r    <= '0;
    end else begin
      prev_err_r <= prev_err_nxt;
      prev_der_r <= prev_der_nxt;
      integ_r    <= integ_nxt;
    end
  end

  // Scratch registers
  always_ff @(posedge clk) begin
    if (load) begin
      err_r <= err_sat;
    end
    if (ctrl.wr == WR_DIFF) begin
      diff_r <= {err_r[DATA_W-1], err_r} - {prev_err_r[DATA_W-1], prev_err_r};
    end
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

endmodule

// ===== sv/pid_filtered_derivative.sv =====
// Top level: PID step with filtered derivative, clamped integral and microcoded control.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  cfg     | cfg_valid/ready, cfg_index, cfg_data     | in
//  in      | in_valid/ready, in_command/setpoint/...  | in
//  out     | out_valid/ready, out_drive               | out
//
// A control step runs control-store steps 0 to 7 in order on the single 33x25
// multiplier; a clear command runs step 0 and then jumps to step 8.
// Reset clears the gains, step and state; the integral limit returns to 10.0.
// in_ready is low while an item is in the sequencer; the next item transfers
// while a finished result waits in the output register, and holds on its
// last step until that result is taken. cfg_ready is always high.
module pid_filtered_derivative (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [31:0]                 in_setpoint,
  input  logic signed [31:0]                 in_measured,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_drive
);
  import pfd_pkg::*;

  cfg_t              cfg_r;
  logic              busy_r;
  logic [PC_W-1:0]   pc_r;
  logic              cmd_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_drive_r;

  ctrl_t             ctrl;
  logic              accept;
  logic              stall;
  logic              finish;
  logic [DATA_W-1:0] dp_drive;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // Control word for the current step; idle issues no writes
  assign ctrl   = busy_r ? ucode(pc_r) : CTRL_NOP;
  assign stall  = ctrl.last && out_valid_r && !out_ready;
  assign finish = ctrl.last && !stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= '0;
      cfg_r.gain_d    <= '0;
      cfg_r.gain_i    <= '0;
      cfg_r.int_step  <= '0;
      cfg_r.int_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:    cfg_r.gain_p    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    cfg_r.gain_d    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    cfg_r.gain_i    <= cfg_data[GAIN_W-1:0];
        REG_INT_STEP:  cfg_r.int_step  <= cfg_data[STEP_W-1:0];
        REG_INT_LIMIT: cfg_r.int_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Step counter with conditional jump
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      cmd_r  <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
      pc_r   <= '0;
      cmd_r  <= in_command;
    end else if (busy_r) begin
      if (finish) begin
        busy_r <= 1'b0;
      end else if (!stall) begin
        pc_r <= (ctrl.jmp_cmd && cmd_r) ? ctrl.jmp_to : pc_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_drive_r <= (ctrl.wr == WR_CLR) ? '0 : dp_drive;
    end
  end

  pfd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .setpoint (in_setpoint),
    .measured (in_measured),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .drive    (dp_drive)
  );

endmodule

// ===== sim/pfd_checker.sv =====
// Checker for the filtered-derivative PID block: tracks register writes, predicts drives and compares.
`timescale 1ns / 100ps

module pfd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [31:0]            in_setpoint,
  input  logic signed [31:0]            in_measured,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [31:0]            out_drive,
  output int                            fail_count,
  output int                            drive_pending,
  output int                            drive_checked
);
  import pfd_pkg::*;

  localparam longint Q_TOP    = 64'sd2147483647;
  localparam longint Q_BOTTOM = -64'sd2147483648;
  localparam int     SHOW_MAX = 10;

  // Shadow copy of the control registers
  logic signed [GAIN_W-1:0] kp, kd, ki;
  logic [STEP_W-1:0]        istep;
  logic [LIMIT_W-1:0]       ilimit;

  // Shadow copy of the loop state
  longint integ_acc, prior_err, last_deriv;

  // Drives still owed by the block, oldest first
  logic signed [31:0] drive_q[$];
  logic signed [31:0] want;

  function automatic longint round_q16(longint x);
    return (x + longint'(ROUND_HALF)) >>> FRAC_W;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > Q_TOP) return Q_TOP;
    if (x < Q_BOTTOM) return Q_BOTTOM;
    return x;
  endfunction

  // One control step (or a clear) on the shadow state
  function automatic logic signed [31:0] next_drive(logic cmd, logic signed [31:0] sp,
                                                    logic signed [31:0] ms);
    longint err, deriv, sum;
    if (cmd) begin
      integ_acc  = 0;
      prior_err  = 0;
      last_deriv = 0;
      return '0;
    end
    err   = clamp32(longint'(sp) - longint'(ms));
    // difference is exact here, 33 bits wide before the filter
    deriv = clamp32(round_q16((err - prior_err) * longint'(FILTER_NEW) +
                              last_deriv * longint'(FILTER_OLD)));
    prior_err  = err;
    last_deriv = deriv;
    integ_acc = integ_acc + round_q16(err * longint'(istep));
    if (integ_acc > longint'(ilimit)) integ_acc = longint'(ilimit);
    if (integ_acc < -longint'(ilimit)) integ_acc = -longint'(ilimit);
    sum = err * longint'(kp) + deriv * longint'(kd) + integ_acc * longint'(ki);
    return 32'(clamp32(round_q16(sum)));
  endfunction

  task automatic report_bad(string what, logic signed [31:0] exp_v, logic signed [31:0] got_v);
    fail_count++;
    if (fail_count <= SHOW_MAX) begin
      $display("[%0t] %s: expected %0d (0x%08h), got %0d (0x%08h)",
               $time, what, exp_v, exp_v, got_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kp            = '0;
      kd            = '0;
      ki            = '0;
      istep         = '0;
      ilimit        = LIMIT_RESET;
      integ_acc     = 0;
      prior_err     = 0;
      last_deriv    = 0;
      fail_count    = 0;
      drive_checked = 0;
      drive_q.delete();
    end else begin
      // result transfer: check against the oldest prediction
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          report_bad("drive with nothing outstanding", '0, out_drive);
        end else begin
          want = drive_q.pop_front();
          drive_checked++;
          if (out_drive !== want) begin
            report_bad("drive mismatch", want, out_drive);
          end
        end
      end
      // register write; spare indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:    kp     = cfg_data[GAIN_W-1:0];
          REG_GAIN_D:    kd     = cfg_data[GAIN_W-1:0];
          REG_GAIN_I:    ki     = cfg_data[GAIN_W-1:0];
          REG_INT_STEP:  istep  = cfg_data[STEP_W-1:0];
          REG_INT_LIMIT: ilimit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // input transfer: predict its drive
      if (in_valid && in_ready) begin
        drive_q.push_back(next_drive(in_command, in_setpoint, in_measured));
      end
    end
    drive_pending = drive_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the filtered-derivative PID block: stimulus, backpressure and verdict.
`timescale 1ns / 100ps

module tb_top;
  import pfd_pkg::*;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic signed [31:0]     Q_HI    = 32'sh7fffffff;
  localparam logic signed [31:0]     Q_LO    = 32'sh80000000;
  localparam logic signed [31:0]     Q_ONE   = 32'sh00010000;
  localparam logic signed [GAIN_W-1:0] GAIN_HI = 24'sh7fffff;
  localparam logic signed [GAIN_W-1:0] GAIN_LO = 24'sh800000;
  localparam logic [STEP_W-1:0]      STEP_TOP  = '1;
  localparam logic [LIMIT_W-1:0]     LIMIT_TOP = '1;
  localparam logic [CFG_IDX_W-1:0]   REG_SPARE_LAST = '1;

  localparam int GAIN_SPAN   = 262144;    // +-4.0
  localparam int TRACK_SPAN  = 13107200;  // +-200.0
  localparam int NOISE_SPAN  = 32768;     // +-0.5
  localparam int LIMIT_SPAN  = 3276800;   // up to 50.0
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [31:0]           cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_command  = 1'b0;
  logic signed [31:0]    in_setpoint = '0;
  logic signed [31:0]    in_measured = '0;
  logic                  out_ready   = 1'b0;
  logic                  cfg_ready, in_ready, out_valid;
  logic signed [31:0]    out_drive;

  int fail_count, drive_pending, drive_checked;
  int burst_left  = 0;
  int items_sent  = 0;
  int clears_sent = 0;
  int loads_done  = 0;
  int track_sp    = 0;
  int track_pv    = 0;

  // receiver state
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       rx_taken  = 0;

  pid_filtered_derivative u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive)
  );

  pfd_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_setpoint   (in_setpoint),
    .in_measured   (in_measured),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .fail_count    (fail_count),
    .drive_pending (drive_pending),
    .drive_checked (drive_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall patterns, plus two long hold-offs to back up the block
  always @(posedge clk) begin
    if (out_valid && out_ready) rx_taken++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready && (rx_taken == 400 || rx_taken == 1000)) begin
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // One transfer on the input channel, with burst/gap pacing
  task automatic send_item(logic cmd, logic signed [31:0] sp, logic signed [31:0] ms);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_setpoint <= sp;
    in_measured <= ms;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  // One register write transfer; caller drops cfg_valid afterwards
  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register load, junk in the unused upper bits, plus a spare-index write
  task automatic load_gains(logic signed [GAIN_W-1:0] p, logic signed [GAIN_W-1:0] d,
                            logic signed [GAIN_W-1:0] i, logic [STEP_W-1:0] st,
                            logic [LIMIT_W-1:0] lim);
    cfg_put(CFG_IDX_W'($urandom_range(REG_INT_LIMIT + 1, REG_SPARE_LAST)), $urandom);
    cfg_put(REG_GAIN_P, {8'($urandom), p});
    cfg_put(REG_GAIN_D, {8'($urandom), d});
    cfg_put(REG_GAIN_I, {8'($urandom), i});
    cfg_put(REG_INT_STEP, {16'($urandom), st});
    cfg_put(REG_INT_LIMIT, {1'($urandom), lim});
    cfg_valid <= 1'b0;
    loads_done++;
  endtask

  // Stop offering and wait for every outstanding drive
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (drive_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 6))
      0: return Q_HI;
      1: return Q_LO;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return GAIN_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? GAIN_HI : GAIN_LO;
      default: return GAIN_W'(int'($urandom_range(0, 2 * GAIN_SPAN)) - GAIN_SPAN);
    endcase
  endfunction

  // Mostly closed-loop style traffic, the rest noise, corners and clears
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item(CMD_CLEAR, $urandom, $urandom);
    end else if (pick < 20) begin
      send_item(CMD_STEP, $urandom, $urandom);
    end else if (pick < 30) begin
      send_item(CMD_STEP, corner_value(), corner_value());
    end else begin
      // target jumps now and then, measurement chases it with noise
      if ($urandom_range(0, 9) == 0) begin
        track_sp = int'($urandom_range(0, 2 * TRACK_SPAN)) - TRACK_SPAN;
      end
      track_pv = track_pv + ((track_sp - track_pv) >>> 2) +
                 int'($urandom_range(0, 2 * NOISE_SPAN)) - NOISE_SPAN;
      send_item(CMD_STEP, track_sp, track_pv);
    end
  endtask

  initial begin
    logic [STEP_W-1:0]  st;
    logic [LIMIT_W-1:0] lim;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains are zero: drive must stay 0
    send_item(CMD_STEP, Q_HI, Q_LO);
    send_item(CMD_STEP, 32'sd12345, -32'sd777);

    // moderate gains, limit back at 10.0
    settle();
    load_gains(24'sd65536, 24'sd32768, 24'sd16384, 16'd32768, LIMIT_RESET);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, Q_ONE, '0);
    send_item(CMD_STEP, Q_HI, Q_LO);          // error saturates high
    send_item(CMD_STEP, Q_HI, Q_LO);          // integral runs into the clamp
    send_item(CMD_STEP, Q_LO, Q_HI);          // saturates low, full-swing difference
    send_item(CMD_STEP, -32'sd1, '0);         // rounding on a tiny negative error
    send_item(CMD_CLEAR, $urandom, $urandom);
    send_item(CMD_STEP, 32'sd229376, 32'sd81920);
    send_item(CMD_STEP, Q_HI, Q_HI);

    // extreme gains and step, widest limit: output saturation both ways
    settle();
    load_gains(GAIN_HI, GAIN_LO, GAIN_HI, STEP_TOP, LIMIT_TOP);
    send_item(CMD_STEP, Q_HI, Q_LO);
    send_item(CMD_STEP, Q_HI, Q_LO);
    send_item(CMD_STEP, Q_LO, Q_HI);
    send_item(CMD_CLEAR, Q_HI, Q_LO);
    send_item(CMD_STEP, '0, 32'sd1);

    // zero limit holds the integral at zero
    settle();
    load_gains(24'sd65536, -24'sd65536, GAIN_HI, STEP_TOP, '0);
    send_item(CMD_STEP, Q_HI, '0);
    send_item(CMD_STEP, 32'sd6553600, -32'sd327680);
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_STEP, -Q_ONE, Q_ONE);

    // random settings, random traffic
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: st = STEP_TOP;
        1: st = STEP_W'($urandom_range(0, 4096));
        default: st = STEP_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: lim = '0;
        1: lim = LIMIT_TOP;
        2, 3: lim = LIMIT_W'($urandom);
        default: lim = LIMIT_W'($urandom_range(0, LIMIT_SPAN));
      endcase
      settle();
      load_gains(rand_gain(), rand_gain(), rand_gain(), st, lim);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d items (%0d state clears) across %0d register loads;",
             items_sent, clears_sent, loads_done);
    $display("compared %0d drives under random output stalls and two long hold-offs.",
             drive_checked);
    if (fail_count == 0 && drive_pending == 0) begin
      $display("PASS pid_filtered_derivative");
    end else begin
      $display("FAIL pid_filtered_derivative");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL pid_filtered_derivative");
    $finish;
  end

endmodule
